>>> src/swerve_drive_inverse_kinematics_defines.svh
// Assertion macros shared by the swerve kinematics RTL.
// Each macro expects clk and rst_n to be in scope of the module that uses it.
`ifndef SWERVE_DRIVE_INVERSE_KINEMATICS_DEFINES_SVH
`define SWERVE_DRIVE_INVERSE_KINEMATICS_DEFINES_SVH

// same-cycle implication
`define SDIK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SDIK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/sdik_pkg.sv
// Shared types, constants and CORDIC angle table for the swerve kinematics block.
// No dependencies.
package sdik_pkg;

  localparam int DW = 32;                 // datapath width of velocity vectors
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 15;
  localparam int DEADBAND_W = 15;
  localparam int RPM_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM  = 1'b1;

  localparam logic signed [63:0] KINV_Q30   = 64'sd652032874;
  localparam logic signed [63:0] SQRT3H_Q30 = 64'sd929887698;

  typedef struct packed {
    logic en;   // whole pipeline advances
    logic vld;  // request entering this unit
  } pipe_ctl_t;

  // atan(2^-i) as a binary angle, 2^32 = full turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;  1:  r = 32'h12E4051E;  2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;  4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;  8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;  10: r = 32'h000A2F98;  11: r = 32'h000517CC;
      12: r = 32'h00028BE6;  13: r = 32'h000145F3;  14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;  16: r = 32'h000028BE;  17: r = 32'h0000145F;
      18: r = 32'h00000A30;  19: r = 32'h00000518;  20: r = 32'h0000028C;
      21: r = 32'h00000146;  22: r = 32'h000000A3;  23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // step angle rounded half up to the angle resolution
  function automatic logic [31:0] step_angle(input int i, input int sh);
    logic [31:0] half;
    half = 32'd1 << (sh - 1);
    return ((atan_turn(i) + half) >> sh) << sh;
  endfunction

endpackage

>>> src/swerve_drive_inverse_kinematics.sv
// Top level of the three-module swerve inverse kinematics pipeline.
// Depends on sdik_pkg, sdik_vec and swerve_drive_inverse_kinematics_defines.svh.
//
// Accepts one command request per clock while no result is stalled at the output and
// returns one result request per command, in order, after these steps: deadband
// and rpm scaling, heading pre-rotation, one rotation CORDIC step per stage, gain
// product, module vector sums, then a vectoring CORDIC per module with one step per
// stage, gain product and rounding. The whole pipeline holds while a result is
// stalled at the output; configuration writes take effect on the next command.
`include "swerve_drive_inverse_kinematics_defines.svh"
module swerve_drive_inverse_kinematics #(
  parameter int ANGLE_BITS = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sdik_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sdik_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [15:0]                 in_cmd_x,
  input  logic signed [15:0]                 in_cmd_y,
  input  logic signed [15:0]                 in_cmd_turn,
  input  logic signed [15:0]                 in_heading,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [15:0]                 out_steer_one,
  output logic signed [15:0]                 out_steer_two,
  output logic signed [15:0]                 out_steer_three,
  output logic [15:0]                        out_speed_one,
  output logic [15:0]                        out_speed_two,
  output logic [15:0]                        out_speed_three
);
  import sdik_pkg::*;

  localparam int N = CORDIC_ITERATIONS;
  localparam int SH = 32 - ANGLE_BITS;
  localparam logic [31:0] AMASK = ~((32'd1 << SH) - 32'd1);

  logic [DEADBAND_W-1:0] deadband_r;
  logic [RPM_W-1:0]      max_rpm_r;
  logic                  en;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= 15'd1638;
      max_rpm_r  <= 10'd500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEADBAND: deadband_r <= cfg_wdata[DEADBAND_W-1:0];
        REG_MAX_RPM:  max_rpm_r  <= cfg_wdata[RPM_W-1:0];
        default: ;
      endcase
    end
  end

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 0: deadband and rpm scaling
  function automatic logic signed [16:0] dband(input logic signed [16:0] v,
                                               input logic [DEADBAND_W-1:0] db);
    logic [16:0] mag;
    mag = v[16] ? 17'(-v) : 17'(v);
    return (mag < {2'b00, db}) ? '0 : v;
  endfunction

  logic signed [16:0] dx, dy, dw;
  logic signed [RPM_W:0] rpm_s;
  always_comb begin
    dx = dband(17'(in_cmd_x), deadband_r);
    dy = dband(17'(in_cmd_y), deadband_r);
    dw = dband(-17'(in_cmd_turn), deadband_r);
    rpm_s = $signed({1'b0, max_rpm_r});
  end

  logic v0_r;
  logic signed [DW-1:0] jx_r, jy_r, jw0_r;
  logic [31:0] a0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      jx_r  <= DW'(dx) * DW'(rpm_s);
      jy_r  <= DW'(dy) * DW'(rpm_s);
      jw0_r <= DW'(dw) * DW'(rpm_s);
      a0_r  <= {in_heading, 16'h0} & AMASK;
    end
  end

  // stage 1: pre-rotate by half a turn when the heading is beyond a quarter turn
  logic signed [DW-1:0] rx_r [0:N];
  logic signed [DW-1:0] ry_r [0:N];
  logic signed [31:0]   rz_r [0:N];
  logic signed [DW-1:0] rw_r [0:N];
  logic                 rv_r [0:N];
  logic signed [31:0]   a0s;
  logic                 wide;
  always_comb begin
    a0s  = $signed(a0_r);
    wide = (a0s > 32'sh40000000) || (a0s < -32'sh40000000);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r[0] <= 1'b0;
    end else if (en) begin
      rv_r[0] <= v0_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rw_r[0] <= jw0_r;
      if (wide) begin
        rx_r[0] <= -jx_r;
        ry_r[0] <= -jy_r;
        rz_r[0] <= a0s ^ 32'sh80000000;
      end else begin
        rx_r[0] <= jx_r;
        ry_r[0] <= jy_r;
        rz_r[0] <= a0s;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic [31:0] T = step_angle(i, SH);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[i+1] <= 1'b0;
      end else if (en) begin
        rv_r[i+1] <= rv_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rw_r[i+1] <= rw_r[i];
        if (rz_r[i] >= 0) begin
          rx_r[i+1] <= rx_r[i] - (ry_r[i] >>> i);
          ry_r[i+1] <= ry_r[i] + (rx_r[i] >>> i);
          rz_r[i+1] <= rz_r[i] - $signed(T);
        end else begin
          rx_r[i+1] <= rx_r[i] + (ry_r[i] >>> i);
          ry_r[i+1] <= ry_r[i] - (rx_r[i] >>> i);
          rz_r[i+1] <= rz_r[i] + $signed(T);
        end
      end
    end
  end

  // gain products
  logic vg_r;
  logic signed [63:0] px_r, py_r, ps_r;
  logic signed [DW-1:0] jwg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else if (en) begin
      vg_r <= rv_r[N];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= 64'(rx_r[N]) * KINV_Q30;
      py_r  <= 64'(ry_r[N]) * KINV_Q30;
      ps_r  <= 64'(rw_r[N]) * SQRT3H_Q30;
      jwg_r <= rw_r[N];
    end
  end

  // module vector sums
  logic signed [63:0] bx64, by64, s364;
  logic signed [DW-1:0] bx, by, s3, hw;
  always_comb begin
    bx64 = (px_r + 64'sd536870912) >>> 30;
    by64 = (py_r + 64'sd536870912) >>> 30;
    s364 = (ps_r + 64'sd536870912) >>> 30;
    bx = bx64[DW-1:0];
    by = by64[DW-1:0];
    s3 = s364[DW-1:0];
    hw = (jwg_r + DW'(1)) >>> 1;
  end

  logic vs_r;
  logic signed [DW-1:0] m1x_r, m1y_r, m2x_r, m2y_r, m3x_r, m3y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else if (en) begin
      vs_r <= vg_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m1x_r <= bx + s3;
      m1y_r <= by + hw;
      m2x_r <= bx - jwg_r;
      m2y_r <= by;
      m3x_r <= bx;
      m3y_r <= by - jwg_r;
    end
  end

  pipe_ctl_t vctl;
  logic      vld_two, vld_three;
  assign vctl = '{en: en, vld: vs_r};

  sdik_vec #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_vec_one (
    .clk(clk), .rst_n(rst_n), .ctl(vctl), .x_i(m1x_r), .y_i(m1y_r),
    .vld_o(out_valid), .angle_o(out_steer_one), .speed_o(out_speed_one)
  );
  sdik_vec #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_vec_two (
    .clk(clk), .rst_n(rst_n), .ctl(vctl), .x_i(m2x_r), .y_i(m2y_r),
    .vld_o(vld_two), .angle_o(out_steer_two), .speed_o(out_speed_two)
  );
  sdik_vec #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_vec_three (
    .clk(clk), .rst_n(rst_n), .ctl(vctl), .x_i(m3x_r), .y_i(m3y_r),
    .vld_o(vld_three), .angle_o(out_steer_three), .speed_o(out_speed_three)
  );

  `SDIK_ASSERT_NOW(a_rot_range, rv_r[0], rz_r[0] <= 32'sh40000000 && rz_r[0] >= -32'sh40000000,
                   "pre-rotated heading out of convergence range")
  `SDIK_ASSERT_NXT(a_hold_on_stall, !en, $stable(vs_r) && $stable(vg_r) && $stable(v0_r),
                   "pipeline moved while stalled")
  `SDIK_ASSERT_NXT(a_no_turn, en && in_valid && in_cmd_turn == 16'sd0, jw0_r == '0,
                   "zero turn request gave turn term")
  `SDIK_ASSERT_NOW(a_lanes_aligned, 1'b1, vld_two == out_valid && vld_three == out_valid,
                   "module lanes out of step")
endmodule

>>> src/sdik_vec.sv
// Pipelined vectoring CORDIC: one module vector to steering angle and wheel speed.
// Depends on sdik_pkg and swerve_drive_inverse_kinematics_defines.svh.
`include "swerve_drive_inverse_kinematics_defines.svh"
module sdik_vec #(
  parameter int ANGLE_BITS = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sdik_pkg::pipe_ctl_t           ctl,
  input  logic signed [sdik_pkg::DW-1:0] x_i,
  input  logic signed [sdik_pkg::DW-1:0] y_i,
  output logic                          vld_o,
  output logic signed [15:0]            angle_o,
  output logic [15:0]                   speed_o
);
  import sdik_pkg::*;

  localparam int N = CORDIC_ITERATIONS;
  localparam int SH = 32 - ANGLE_BITS;

  logic signed [DW-1:0] x_r [0:N];
  logic signed [DW-1:0] y_r [0:N];
  logic [31:0]          z_r [0:N];
  logic                 zero_r [0:N];
  logic                 vld_r [0:N];

  logic signed [63:0]   prod_r;
  logic [31:0]          zg_r;
  logic                 zerog_r, vldg_r;

  logic signed [15:0]   angle_r;
  logic [15:0]          speed_r;
  logic                 vldo_r;

  logic                 zero_in;
  logic signed [63:0]   t_nxt, m_nxt;
  logic [31:0]          zr_nxt;

  assign zero_in = (x_i == '0) && (y_i == '0);

  // entry: fold left half-plane onto the right
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (ctl.en) begin
      vld_r[0] <= ctl.vld;
    end
  end
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      zero_r[0] <= zero_in;
      if (x_i < 0) begin
        x_r[0] <= -x_i;
        y_r[0] <= -y_i;
        z_r[0] <= 32'h80000000;
      end else begin
        x_r[0] <= x_i;
        y_r[0] <= y_i;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    localparam logic [31:0] T = step_angle(i, SH);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] < 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - T;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + T;
        end
      end
    end
  end

  // gain removal product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldg_r <= 1'b0;
    end else if (ctl.en) begin
      vldg_r <= vld_r[N];
    end
  end
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r  <= 64'(x_r[N]) * KINV_Q30;
      zg_r    <= z_r[N];
      zerog_r <= zero_r[N];
    end
  end

  always_comb begin
    t_nxt  = (prod_r + 64'sd536870912) >>> 30;
    m_nxt  = (t_nxt + 64'sd1024) >>> 11;
    zr_nxt = zg_r + 32'h8000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldo_r <= 1'b0;
    end else if (ctl.en) begin
      vldo_r <= vldg_r;
    end
  end
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (zerog_r) begin
        angle_r <= '0;
        speed_r <= '0;
      end else begin
        angle_r <= zr_nxt[31:16];
        if (m_nxt < 0) begin
          speed_r <= '0;
        end else if (m_nxt > 64'sd65535) begin
          speed_r <= 16'hFFFF;
        end else begin
          speed_r <= m_nxt[15:0];
        end
      end
    end
  end

  assign vld_o   = vldo_r;
  assign angle_o = angle_r;
  assign speed_o = speed_r;

  `SDIK_ASSERT_NOW(a_entry_right_half, vld_r[0], x_r[0] >= 0, "vectoring entry x negative")
  `SDIK_ASSERT_NOW(a_exit_nonneg, vld_r[N], x_r[N] >= 0, "vectoring result x negative")
  `SDIK_ASSERT_NXT(a_zero_out, ctl.en && vldg_r && zerog_r, speed_r == '0 && angle_r == '0,
                   "zero vector gave nonzero output")
endmodule

>>> dv/swerve_drive_inverse_kinematics_test.sv
// Self-checking bench for the three-module swerve inverse kinematics pipeline.
// Depends on sdik_pkg and swerve_drive_inverse_kinematics; predicts each module's angle and speed.
module swerve_drive_inverse_kinematics_test;
  import sdik_pkg::*;

  localparam int ITERS = 16;
  localparam int ASHIFT = 16;
  localparam int LATENCY = 2 * ITERS + 7;

  typedef struct {
    logic signed [15:0] steer [3];
    logic [15:0] speed [3];
  } wheel_set_t;

  // floor shift
  function automatic longint asr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint rnd_half_up(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  class wheel_scoreboard;
    int unsigned deadband_q15 = 1638;
    int unsigned rpm_limit = 500;
    wheel_set_t pending[$];
    int errors;

    function longint gate(longint v);
      longint mag;
      mag = v < 0 ? -v : v;
      return mag < longint'(deadband_q15) ? 0 : v;
    endfunction

    function void vectorise(longint x, longint y, output logic [15:0] ang,
                            output logic [15:0] spd);
      bit [31:0] z;
      longint dx, dy, mag;
      z = 0;
      if (x == 0 && y == 0) begin
        ang = 0;
        spd = 0;
        return;
      end
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h80000000;
      end
      for (int i = 0; i < ITERS; i++) begin
        dx = asr(y, i);
        dy = asr(x, i);
        if (y < 0) begin
          x -= dx; y += dy; z -= step_angle(i, ASHIFT);
        end else begin
          x += dx; y -= dy; z += step_angle(i, ASHIFT);
        end
      end
      ang = 16'((z + 32'h8000) >> 16);
      mag = rnd_half_up(rnd_half_up(x * KINV_Q30, 30), 11);
      if (mag < 0) mag = 0;
      spd = mag > 65535 ? 16'hFFFF : 16'(mag);
    endfunction

    function void note_command(logic signed [15:0] cx, logic signed [15:0] cy,
                               logic signed [15:0] cw, logic signed [15:0] hd);
      longint jx, jy, jw, x, y, z, dx, dy, t, bx, by, s3, hw;
      wheel_set_t r;
      jx = gate(longint'(cx)) * rpm_limit;
      jy = gate(longint'(cy)) * rpm_limit;
      jw = gate(-longint'(cw)) * rpm_limit;
      z = longint'(int'({hd, 16'h0}));
      x = jx;
      y = jy;
      if (z > (longint'(1) << 30) || z < -(longint'(1) << 30)) begin
        x = -x;
        y = -y;
        z += z < 0 ? (longint'(1) << 31) : -(longint'(1) << 31);
      end
      for (int i = 0; i < ITERS; i++) begin
        dx = asr(y, i);
        dy = asr(x, i);
        t = longint'(step_angle(i, ASHIFT));
        if (z >= 0) begin
          x -= dx; y += dy; z -= t;
        end else begin
          x += dx; y -= dy; z += t;
        end
      end
      bx = rnd_half_up(x * KINV_Q30, 30);
      by = rnd_half_up(y * KINV_Q30, 30);
      s3 = rnd_half_up(jw * SQRT3H_Q30, 30);
      hw = rnd_half_up(jw, 1);
      vectorise(bx + s3, by + hw, r.steer[0], r.speed[0]);
      vectorise(bx - jw, by, r.steer[1], r.speed[1]);
      vectorise(bx, by - jw, r.steer[2], r.speed[2]);
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [15:0] st [3], logic [15:0] sp [3]);
      wheel_set_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result steer %0d/%0d/%0d", $time, st[0], st[1], st[2]);
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int m = 0; m < 3; m++) begin
        if (st[m] !== e.steer[m]) begin
          $display("%0t: steer %0d expected %0d got %0d", $time, m, e.steer[m], st[m]);
          errors++;
        end
        if (sp[m] !== e.speed[m]) begin
          $display("%0t: speed %0d expected %0d got %0d", $time, m, e.speed[m], sp[m]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DEADBAND;
  logic [CFG_DATA_W-1:0] cfg_wdata = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] in_cmd_x = 0, in_cmd_y = 0, in_cmd_turn = 0, in_heading = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] out_steer_one, out_steer_two, out_steer_three;
  logic [15:0] out_speed_one, out_speed_two, out_speed_three;

  wheel_scoreboard sb = new();
  bit sending_done = 0;

  swerve_drive_inverse_kinematics uut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stall, check on accept
  initial begin
    logic signed [15:0] st [3];
    logic [15:0] sp [3];
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        st = '{out_steer_one, out_steer_two, out_steer_three};
        sp = '{out_speed_one, out_speed_two, out_speed_three};
        sb.check_result(st, sp);
      end
      @(negedge clk);
      out_stall <= ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
    end
  end

  // valid stays high after a request; the next call lowers it only when it inserts a gap, and drain() lowers it
  task automatic send_command(logic signed [15:0] cx, logic signed [15:0] cy,
                              logic signed [15:0] cw, logic signed [15:0] hd);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    in_cmd_x <= cx;
    in_cmd_y <= cy;
    in_cmd_turn <= cw;
    in_heading <= hd;
    do @(posedge clk); while (in_stall);
    sb.note_command(cx, cy, cw, hd);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_DEADBAND) sb.deadband_q15 = val & 32'h7FFF;
    else sb.rpm_limit = val & 32'h3FF;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic signed [15:0] near_edge(int unsigned db);
    int v;
    v = int'(db) + $urandom_range(0, 2) - 1;
    if ($urandom_range(0, 1)) v = -v;
    return 16'(v);
  endfunction

  initial begin
    logic signed [15:0] ext [6];
    int unsigned dbs [5];
    int unsigned rpms [5];
    ext = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh4000, 16'shC000};
    dbs = '{1638, 0, 32767, 1, 300};
    rpms = '{500, 1023, 0, 1, 777};
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, zero vector, straight back, wide heading, saturation
    send_command(0, 0, 0, 0);
    send_command(16'sh8000, 0, 0, 0);
    send_command(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_command(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_command(0, 0, 16'sh8000, 0);
    send_command(16'sh7FFF, 0, 0, 16'sh4001);
    send_command(16'sh7FFF, 0, 0, 16'shBFFF);
    send_command(16'sh7FFF, 0, 0, 16'sh4000);
    send_command(16'sh7FFF, 0, 0, 16'shC000);
    send_command(16'sh8000, 0, 0, 16'sh0000);
    send_command(0, 16'sh7FFF, 0, 16'sh2000);
    send_command(16'd1637, 16'd1638, -16'sd1638, 16'shFFFF);
    send_command(-16'sd1637, 0, 16'd1637, 16'sh0001);
    send_command(0, 0, 16'sh4000, 16'sh6000);
    drain();
    write_reg(REG_MAX_RPM, 1023);
    send_command(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh1000);
    send_command(16'sh8000, 16'sh8000, 16'sh7FFF, 16'shE000);
    drain();
    write_reg(REG_MAX_RPM, 500);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(REG_DEADBAND, dbs[ph]);
      write_reg(REG_MAX_RPM, rpms[ph]);
      for (int n = 0; n < 370; n++) begin
        int k;
        logic signed [15:0] f [4];
        k = $urandom_range(0, 9);
        for (int j = 0; j < 4; j++) begin
          if (k == 0) f[j] = ext[$urandom_range(0, 5)];
          else if (k == 1 && j < 3) f[j] = near_edge(dbs[ph]);
          else if (k == 2 && j < 3) f[j] = 16'($signed($urandom_range(0, 4000)) - 2000);
          else f[j] = 16'($urandom);
        end
        send_command(f[0], f[1], f[2], f[3]);
      end
    end
    in_valid <= 0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+src
src/sdik_pkg.sv
src/sdik_vec.sv
src/swerve_drive_inverse_kinematics.sv
dv/swerve_drive_inverse_kinematics_test.sv
